### sv/radio_frame_crc16_checker_macros.svh
`ifndef RADIO_FRAME_CRC16_CHECKER_MACROS_SVH
`define RADIO_FRAME_CRC16_CHECKER_MACROS_SVH

// Checked while out of reset.
`define RFCRC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included.
`define RFCRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rfcrc_pkg.sv
package rfcrc_pkg;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcSeed = 16'h1D0F;

  localparam int unsigned PosW = 3;
  localparam logic [PosW-1:0] HdrPos  = 3'd2;
  localparam logic [PosW-1:0] LastPos = 3'd6;
  localparam int unsigned StoreDepth = 6;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusHdrErr = 2'd1,
    StatusTrlErr = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
    logic [3:0] out_low_nibble;
    logic [2:0] out_mid_scaled;
    logic [2:0] out_top_plus_one;
  } out_item_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [3:0] low_nibble;
    logic [2:0] mid_scaled;
    logic [2:0] top_plus_one;
  } held_t;

  // MSB-first CRC-16 over one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int b = 7; b >= 0; b--) begin
      fb = c[15] ^ data[b];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

### sv/rfcrc_in_reg.sv
module rfcrc_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rfcrc_pkg::in_item_t in_item_i,
  output logic                item_valid_o,
  output rfcrc_pkg::in_item_t item_o,
  input  logic                pop_i
);

  logic                valid_q, valid_d;
  rfcrc_pkg::in_item_t item_q;

  assign in_ready_o = !valid_q || pop_i;

  always_comb begin
    valid_d = valid_q;
    if (pop_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### sv/rfcrc_frame_check.sv
`include "radio_frame_crc16_checker_macros.svh"

module rfcrc_frame_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rfcrc_pkg::in_item_t  item_i,
  input  logic                 take_i,
  output logic                 has_result_o,
  output rfcrc_pkg::out_item_t result_o
);

  logic [rfcrc_pkg::PosW-1:0] pos_q, pos_eff;
  logic [15:0]                crc_q, crc_base, crc_next, snap_q;
  logic [7:0]                 store_q [rfcrc_pkg::StoreDepth];
  rfcrc_pkg::held_t           held_q, held_new, held_out;
  rfcrc_pkg::status_e         status;
  logic                       is_last, frame_ok;

  always_comb begin
    pos_eff = pos_q;
    if (item_i.frame_start || pos_q > rfcrc_pkg::LastPos) begin
      pos_eff = '0;
    end
  end

  assign crc_base = item_i.frame_start ? rfcrc_pkg::CrcSeed : crc_q;
  assign crc_next = rfcrc_pkg::crc16_byte(crc_base, item_i.rx_byte);
  assign is_last  = (pos_eff == rfcrc_pkg::LastPos);

  always_comb begin
    if (snap_q != {store_q[3], store_q[4]}) begin
      status = rfcrc_pkg::StatusHdrErr;
    end else if (crc_base[7:0] != item_i.rx_byte) begin
      status = rfcrc_pkg::StatusTrlErr;
    end else begin
      status = rfcrc_pkg::StatusOk;
    end
  end

  assign frame_ok = (status == rfcrc_pkg::StatusOk);

  always_comb begin
    held_new.first        = store_q[0];
    held_new.second       = store_q[1];
    held_new.third        = store_q[2];
    held_new.low_nibble   = store_q[5][3:0];
    held_new.mid_scaled   = {store_q[5][5:4], 1'b0};
    held_new.top_plus_one = {1'b0, store_q[5][7:6]} + 3'd1;
  end

  assign held_out = frame_ok ? held_new : held_q;

  always_comb begin
    result_o.status           = status;
    result_o.out_first        = held_out.first;
    result_o.out_second       = held_out.second;
    result_o.out_third        = held_out.third;
    result_o.out_low_nibble   = held_out.low_nibble;
    result_o.out_mid_scaled   = held_out.mid_scaled;
    result_o.out_top_plus_one = held_out.top_plus_one;
  end

  assign has_result_o = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      crc_q  <= rfcrc_pkg::CrcSeed;
      snap_q <= '0;
      held_q <= '0;
    end else if (take_i) begin
      if (is_last) begin
        pos_q <= '0;
        crc_q <= rfcrc_pkg::CrcSeed;
        if (frame_ok) begin
          held_q <= held_new;
        end
      end else begin
        pos_q <= pos_eff + 3'd1;
        crc_q <= crc_next;
        if (pos_eff == rfcrc_pkg::HdrPos) begin
          snap_q <= crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && !is_last) begin
      store_q[pos_eff] <= item_i.rx_byte;
    end
  end

  `RFCRC_ASSERT(a_frame_end_reseed, clk_i, rst_ni,
    take_i && is_last |=> pos_q == '0 && crc_q == rfcrc_pkg::CrcSeed,
    "frame end did not reseed")
  `RFCRC_ASSERT(a_hdr_snapshot, clk_i, rst_ni,
    take_i && pos_eff == rfcrc_pkg::HdrPos |=> snap_q == crc_q,
    "header snapshot differs from crc")
  `RFCRC_ASSERT(a_held_only_on_ok, clk_i, rst_ni,
    !(take_i && is_last && frame_ok) |=> $stable(held_q),
    "held fields changed without a good frame")
  `RFCRC_ASSERT_ALWAYS(a_pos_range, clk_i,
    !rst_ni || pos_q <= rfcrc_pkg::LastPos,
    "byte position out of range")

endmodule

### sv/rfcrc_out_reg.sv
module rfcrc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  rfcrc_pkg::out_item_t result_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rfcrc_pkg::out_item_t out_item_o
);

  logic                 valid_q, valid_d;
  rfcrc_pkg::out_item_t item_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

### sv/radio_frame_crc16_checker.sv
// Checks 7-byte radio frames fed one byte per transaction. Bytes 0-2 are
// covered by a CRC-16 (poly 0x1021, seed 0x1D0F, MSB first) that must match
// bytes 3-4; the CRC over bytes 0-5 must match byte 6 in its low byte. Byte 6
// yields one result: status (0 ok, 1 header mismatch, 2 trailer mismatch)
// plus the decoded fields of the last good frame. frame_start restarts a
// frame at any byte. One byte is taken every cycle unless an output stall
// holds the last byte of a frame; out_valid_o rises once that last byte has
// passed the input register and then the result register. Each byte feeds
// the CRC register through a combinational byte update. An output stall holds
// a pending last byte in the input register, which then drops in_ready_o.
module radio_frame_crc16_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rfcrc_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rfcrc_pkg::out_item_t out_item_o
);

  logic                 item_valid, take, has_result, out_space;
  rfcrc_pkg::in_item_t  item;
  rfcrc_pkg::out_item_t result;

  assign take = item_valid && (!has_result || out_space);

  rfcrc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .pop_i        (take)
  );

  rfcrc_frame_check u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .take_i       (take),
    .has_result_o (has_result),
    .result_o     (result)
  );

  rfcrc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && has_result),
    .result_i    (result),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### bench/tb_radio_frame_crc16_checker.sv
`timescale 1ns / 1ps

module tb_radio_frame_crc16_checker;

  localparam int unsigned RandItems = 1550;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned DirRows = 23;

  // where a byte value comes from when it is driven
  typedef enum logic [2:0] {
    FillLit,
    FillHdrHi,
    FillHdrHiBad,
    FillHdrLo,
    FillHdrLoBad,
    FillTrl,
    FillTrlBad
  } fill_e;

  typedef enum int {
    KindGood,
    KindHdrBad,
    KindTrlBad,
    KindPartial,
    KindNoise
  } frame_kind_e;

  typedef struct packed {
    logic [7:0]           data;
    logic                 sof;
    fill_e                fill;
    logic                 typed;
    rfcrc_pkg::out_item_t want;
  } stim_row_t;

  localparam rfcrc_pkg::out_item_t NoResult = '0;
  localparam rfcrc_pkg::out_item_t HdrErrFromReset =
    '{status: rfcrc_pkg::StatusHdrErr, default: '0};

  localparam stim_row_t DirTable [DirRows] = '{
    // all-zero frame: header can never match, held fields still at reset
    '{8'h00, 1'b1, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b1, HdrErrFromReset},
    // good frame without frame_start, all ones
    '{8'hFF, 1'b0, FillLit, 1'b0, NoResult},
    '{8'hFF, 1'b0, FillLit, 1'b0, NoResult},
    '{8'hFF, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillHdrHi, 1'b0, NoResult},
    '{8'h00, 1'b0, FillHdrLo, 1'b0, NoResult},
    '{8'hFF, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillTrl, 1'b0, NoResult},
    // partial frame dropped by restart
    '{8'hA5, 1'b1, FillLit, 1'b0, NoResult},
    '{8'h5A, 1'b0, FillLit, 1'b0, NoResult},
    // trailer mismatch, held fields kept
    '{8'h80, 1'b1, FillLit, 1'b0, NoResult},
    '{8'h7F, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h01, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillHdrHi, 1'b0, NoResult},
    '{8'h00, 1'b0, FillHdrLo, 1'b0, NoResult},
    '{8'h00, 1'b0, FillLit, 1'b0, NoResult},
    '{8'h00, 1'b0, FillTrlBad, 1'b0, NoResult}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rfcrc_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rfcrc_pkg::out_item_t out_item;

  // frame tracker state
  logic [rfcrc_pkg::PosW-1:0] frame_pos = '0;
  logic [15:0]                crc_acc = rfcrc_pkg::CrcSeed;
  logic [15:0]                hdr_snap = '0;
  logic [7:0]                 frame_bytes [7];
  rfcrc_pkg::held_t           held = '0;

  rfcrc_pkg::out_item_t verdict_q [$];
  logic                 row_typed = 1'b0;
  rfcrc_pkg::out_item_t row_want = '0;
  logic                 calm = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          mismatch_cnt = 0;
  int unsigned          item_cnt = 0;
  int unsigned          quiet_cycles = 0;

  radio_frame_crc16_checker uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc_shift_byte(logic [15:0] acc, logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ d[i]) begin
        r = {r[14:0], 1'b0} ^ rfcrc_pkg::CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic track_frame_byte(input rfcrc_pkg::in_item_t it, output logic emits,
                                  output rfcrc_pkg::out_item_t res);
    logic [7:0] b5;
    emits = 1'b0;
    res = '0;
    if (it.frame_start) begin
      frame_pos = '0;
      crc_acc = rfcrc_pkg::CrcSeed;
    end
    if (frame_pos > rfcrc_pkg::LastPos) begin
      frame_pos = '0;
    end
    frame_bytes[frame_pos] = it.rx_byte;
    if (frame_pos < rfcrc_pkg::LastPos) begin
      crc_acc = crc_shift_byte(crc_acc, it.rx_byte);
      if (frame_pos == rfcrc_pkg::HdrPos) begin
        hdr_snap = crc_acc;
      end
      frame_pos = frame_pos + 1'b1;
    end else begin
      if (hdr_snap != {frame_bytes[3], frame_bytes[4]}) begin
        res.status = rfcrc_pkg::StatusHdrErr;
      end else if (crc_acc[7:0] != it.rx_byte) begin
        res.status = rfcrc_pkg::StatusTrlErr;
      end else begin
        res.status = rfcrc_pkg::StatusOk;
        b5 = frame_bytes[5];
        held.first = frame_bytes[0];
        held.second = frame_bytes[1];
        held.third = frame_bytes[2];
        held.low_nibble = b5[3:0];
        held.mid_scaled = {b5[5:4], 1'b0};
        held.top_plus_one = {1'b0, b5[7:6]} + 3'd1;
      end
      res.out_first = held.first;
      res.out_second = held.second;
      res.out_third = held.third;
      res.out_low_nibble = held.low_nibble;
      res.out_mid_scaled = held.mid_scaled;
      res.out_top_plus_one = held.top_plus_one;
      frame_pos = '0;
      crc_acc = rfcrc_pkg::CrcSeed;
      emits = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    logic                 emits;
    rfcrc_pkg::out_item_t guess;
    rfcrc_pkg::out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        track_frame_byte(in_item, emits, guess);
        if (emits) begin
          verdict_q.push_back(row_typed ? row_want : guess);
        end
      end
      if (out_valid && out_ready) begin
        stall_left = calm ? 0 : $urandom_range(0, 13);
        if (verdict_q.size() == 0) begin
          $error("result transaction with none expected");
          mismatch_cnt++;
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 8'(want.status), 8'(out_item.status));
          check_field("out_first", want.out_first, out_item.out_first);
          check_field("out_second", want.out_second, out_item.out_second);
          check_field("out_third", want.out_third, out_item.out_third);
          check_field("out_low_nibble", 8'(want.out_low_nibble),
                      8'(out_item.out_low_nibble));
          check_field("out_mid_scaled", 8'(want.out_mid_scaled),
                      8'(out_item.out_mid_scaled));
          check_field("out_top_plus_one", 8'(want.out_top_plus_one),
                      8'(out_item.out_top_plus_one));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_radio_frame_crc16_checker: done, errors");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_row(input stim_row_t row);
    int unsigned gap;
    logic [7:0]  b;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    case (row.fill)
      FillHdrHi:    b = hdr_snap[15:8];
      FillHdrHiBad: b = hdr_snap[15:8] ^ 8'($urandom_range(1, 255));
      FillHdrLo:    b = hdr_snap[7:0];
      FillHdrLoBad: b = hdr_snap[7:0] ^ 8'($urandom_range(1, 255));
      FillTrl:      b = crc_acc[7:0];
      FillTrlBad:   b = crc_acc[7:0] ^ 8'($urandom_range(1, 255));
      default:      b = row.data;
    endcase
    in_item <= '{rx_byte: b, frame_start: row.sof};
    row_typed = row.typed;
    row_want = row.want;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    item_cnt++;
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof, input fill_e fill);
    drive_row('{b, sof, fill, 1'b0, NoResult});
  endtask

  task automatic send_frame(input frame_kind_e kind);
    logic        sof;
    logic        hi_bad;
    int unsigned cut;
    // rely on end-of-frame rollover sometimes, but never mid-frame
    sof = (frame_pos != '0) || ($urandom_range(0, 3) != 0);
    case (kind)
      KindGood, KindTrlBad: begin
        send_byte(8'($urandom), sof, FillLit);
        send_byte(8'($urandom), 1'b0, FillLit);
        send_byte(8'($urandom), 1'b0, FillLit);
        send_byte(8'h00, 1'b0, FillHdrHi);
        send_byte(8'h00, 1'b0, FillHdrLo);
        send_byte(8'($urandom), 1'b0, FillLit);
        send_byte(8'h00, 1'b0, (kind == KindGood) ? FillTrl : FillTrlBad);
      end
      KindHdrBad: begin
        hi_bad = 1'($urandom_range(0, 1));
        send_byte(8'($urandom), sof, FillLit);
        send_byte(8'($urandom), 1'b0, FillLit);
        send_byte(8'($urandom), 1'b0, FillLit);
        send_byte(8'h00, 1'b0, hi_bad ? FillHdrHiBad : FillHdrHi);
        send_byte(8'h00, 1'b0, hi_bad ? FillHdrLo : FillHdrLoBad);
        send_byte(8'($urandom), 1'b0, FillLit);
        send_byte(8'($urandom), 1'b0, ($urandom_range(0, 1) != 0) ? FillTrl : FillLit);
      end
      KindPartial: begin
        cut = $urandom_range(1, 6);
        for (int i = 0; i < cut; i++) begin
          send_byte(8'($urandom), (i == 0), FillLit);
        end
      end
      default: begin
        for (int i = 0; i < 7; i++) begin
          send_byte(8'($urandom), ($urandom_range(0, 7) == 0), FillLit);
        end
      end
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned frames;
    int unsigned target;
    frame_kind_e kind;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++) begin
      drive_row(DirTable[i]);
    end
    drain_results();

    frames = 0;
    target = item_cnt + RandItems;
    while (item_cnt < target) begin
      if (frames % 8 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      if (frames == 120) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        kind = KindGood;
      end else if (pick < 60) begin
        kind = KindHdrBad;
      end else if (pick < 75) begin
        kind = KindTrlBad;
      end else if (pick < 85) begin
        kind = KindPartial;
      end else begin
        kind = KindNoise;
      end
      send_frame(kind);
      frames++;
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("tb_radio_frame_crc16_checker: done, clean");
    end else begin
      $display("tb_radio_frame_crc16_checker: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/rfcrc_pkg.sv
sv/rfcrc_in_reg.sv
sv/rfcrc_frame_check.sv
sv/rfcrc_out_reg.sv
sv/radio_frame_crc16_checker.sv
bench/tb_radio_frame_crc16_checker.sv
